// ----- sv/fla_pkg.sv -----
// ---------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free list heap allocator
// arena geometry, block table entry, controller states, commands and status
// ---------------------------------------------------------------------------
package fla_pkg;

	// arena geometry
	localparam int ARENA_BYTES        = 4096;
	localparam int ALIGN_BYTES        = 8;
	localparam int ALLOC_HEADER_BYTES = 8;
	localparam int FREE_HEADER_BYTES  = 16;
	localparam int ARENA_HEADER_BYTES = 16;
	localparam int GRAN_N             = ARENA_BYTES / ALIGN_BYTES;
	localparam int GRAN_W             = $clog2(GRAN_N);
	localparam int LINK_W             = GRAN_W + 1;
	localparam int LEN_W              = 13;
	localparam int ADDR_W             = 12;
	localparam int SIZE_W             = 12;

	localparam logic [LINK_W-1:0] LINK_NIL   = '1;
	localparam logic [LINK_W-1:0] FIRST_GRAN = LINK_W'(ARENA_HEADER_BYTES / ALIGN_BYTES);
	localparam logic [LEN_W-1:0]  FULL_LEN   = LEN_W'(ARENA_BYTES - ARENA_HEADER_BYTES);

	// fit policies
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// result codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
	localparam logic [1:0] ST_FREE_REJ   = 2'd2;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// one block table entry, kept at a block's starting granule
	typedef struct packed {
		logic              is_free;
		logic [LINK_W-1:0] link;
		logic [LEN_W-1:0]  len;
	} entry_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE,
		S_A_START, S_A_EVAL, S_A_FINISH, S_A_PREV_RD, S_A_PREV_WR, S_A_CHOSEN_WR,
		S_F_START, S_F_HEAD, S_F_CHAIN, S_F_LSTART, S_F_LIST, S_F_INS, S_F_INS2,
		S_F_NEXT, S_F_MERGE, S_F_MERGE2, S_RESP
	} state_t;

	typedef enum logic [4:0] {
		C_INIT, C_IDLE,
		C_A_START, C_A_EVAL, C_A_FINISH, C_A_PREV_RD, C_A_PREV_WR, C_A_CHOSEN_WR,
		C_F_START, C_F_HEAD, C_F_CHAIN, C_F_LSTART, C_F_LIST, C_F_INS, C_F_INS2,
		C_F_NEXT, C_F_MERGE, C_F_MERGE2, C_RESP
	} cmd_t;

	// decisions reported by the datapath
	typedef struct packed {
		logic size_zero;
		logic head_null;
		logic a_more;
		logic a_found;
		logic a_cprev_null;
		logic f_bad;
		logic f_head_full;
		logic f_chain_hit;
		logic f_chain_end;
		logic f_list_start;
		logic f_list_more;
		logic f_ins_two;
		logic f_merge;
		logic out_free;
	} stat_t;

endpackage

// ----- sv/fla_ctrl.sv -----
// ---------------------------------------------------------------------------
// fla_ctrl: request sequencer
// steps the datapath through the list walks and table updates of each request
// ---------------------------------------------------------------------------
module fla_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            req_type,
	input  fla_pkg::stat_t  stat,
	output logic            in_ready,
	output fla_pkg::cmd_t   cmd
);

	fla_pkg::state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fla_pkg::S_INIT;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			fla_pkg::S_INIT: state_nx = fla_pkg::S_IDLE;
			fla_pkg::S_IDLE: begin
				if (in_valid)
					state_nx = (req_type == fla_pkg::REQ_FREE) ? fla_pkg::S_F_START
						: fla_pkg::S_A_START;
			end
			fla_pkg::S_A_START: begin
				priority if (stat.size_zero) state_nx = fla_pkg::S_RESP;
				else if (stat.head_null) state_nx = fla_pkg::S_A_FINISH;
				else state_nx = fla_pkg::S_A_EVAL;
			end
			fla_pkg::S_A_EVAL: if (!stat.a_more) state_nx = fla_pkg::S_A_FINISH;
			fla_pkg::S_A_FINISH: begin
				priority if (!stat.a_found) state_nx = fla_pkg::S_RESP;
				else if (stat.a_cprev_null) state_nx = fla_pkg::S_A_CHOSEN_WR;
				else state_nx = fla_pkg::S_A_PREV_RD;
			end
			fla_pkg::S_A_PREV_RD: state_nx = fla_pkg::S_A_PREV_WR;
			fla_pkg::S_A_PREV_WR: state_nx = fla_pkg::S_A_CHOSEN_WR;
			fla_pkg::S_A_CHOSEN_WR: state_nx = fla_pkg::S_RESP;
			fla_pkg::S_F_START:
				state_nx = stat.f_bad ? fla_pkg::S_RESP : fla_pkg::S_F_HEAD;
			fla_pkg::S_F_HEAD:
				state_nx = stat.f_head_full ? fla_pkg::S_RESP : fla_pkg::S_F_CHAIN;
			fla_pkg::S_F_CHAIN: begin
				priority if (stat.f_chain_hit) state_nx = fla_pkg::S_F_LSTART;
				else if (stat.f_chain_end) state_nx = fla_pkg::S_RESP;
				else state_nx = fla_pkg::S_F_CHAIN;
			end
			fla_pkg::S_F_LSTART:
				state_nx = stat.f_list_start ? fla_pkg::S_F_LIST : fla_pkg::S_F_INS;
			fla_pkg::S_F_LIST: if (!stat.f_list_more) state_nx = fla_pkg::S_F_INS;
			fla_pkg::S_F_INS:
				state_nx = stat.f_ins_two ? fla_pkg::S_F_INS2 : fla_pkg::S_F_NEXT;
			fla_pkg::S_F_INS2: state_nx = fla_pkg::S_F_NEXT;
			fla_pkg::S_F_NEXT:
				state_nx = stat.f_merge ? fla_pkg::S_F_MERGE : fla_pkg::S_RESP;
			fla_pkg::S_F_MERGE: state_nx = fla_pkg::S_F_MERGE2;
			fla_pkg::S_F_MERGE2: state_nx = fla_pkg::S_RESP;
			fla_pkg::S_RESP: if (stat.out_free) state_nx = fla_pkg::S_IDLE;
			default: state_nx = fla_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd = fla_pkg::C_IDLE;
		unique case (state_q)
			fla_pkg::S_INIT: cmd = fla_pkg::C_INIT;
			fla_pkg::S_IDLE: begin
				cmd = fla_pkg::C_IDLE;
				in_ready = 1'b1;
			end
			fla_pkg::S_A_START: cmd = fla_pkg::C_A_START;
			fla_pkg::S_A_EVAL: cmd = fla_pkg::C_A_EVAL;
			fla_pkg::S_A_FINISH: cmd = fla_pkg::C_A_FINISH;
			fla_pkg::S_A_PREV_RD: cmd = fla_pkg::C_A_PREV_RD;
			fla_pkg::S_A_PREV_WR: cmd = fla_pkg::C_A_PREV_WR;
			fla_pkg::S_A_CHOSEN_WR: cmd = fla_pkg::C_A_CHOSEN_WR;
			fla_pkg::S_F_START: cmd = fla_pkg::C_F_START;
			fla_pkg::S_F_HEAD: cmd = fla_pkg::C_F_HEAD;
			fla_pkg::S_F_CHAIN: cmd = fla_pkg::C_F_CHAIN;
			fla_pkg::S_F_LSTART: cmd = fla_pkg::C_F_LSTART;
			fla_pkg::S_F_LIST: cmd = fla_pkg::C_F_LIST;
			fla_pkg::S_F_INS: cmd = fla_pkg::C_F_INS;
			fla_pkg::S_F_INS2: cmd = fla_pkg::C_F_INS2;
			fla_pkg::S_F_NEXT: cmd = fla_pkg::C_F_NEXT;
			fla_pkg::S_F_MERGE: cmd = fla_pkg::C_F_MERGE;
			fla_pkg::S_F_MERGE2: cmd = fla_pkg::C_F_MERGE2;
			fla_pkg::S_RESP: cmd = fla_pkg::C_RESP;
			default: cmd = fla_pkg::C_IDLE;
		endcase
	end

endmodule

// ----- sv/fla_dpath.sv -----
// ---------------------------------------------------------------------------
// fla_dpath: block table memory, walk registers and result register
// executes one controller command per cycle and reports its decisions
// ---------------------------------------------------------------------------
module fla_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fla_pkg::cmd_t                cmd,
	input  logic                         in_valid,
	input  logic [fla_pkg::SIZE_W-1:0]   alloc_size,
	input  logic [fla_pkg::ADDR_W-1:0]   free_addr,
	input  logic                         cfg_valid,
	input  logic [1:0]                   fit_policy,
	input  logic                         out_ready,
	output fla_pkg::stat_t               stat,
	output logic                         out_valid,
	output logic [fla_pkg::ADDR_W-1:0]   result_addr,
	output logic [1:0]                   status
);

	localparam int GW = fla_pkg::GRAN_W;
	localparam int LW = fla_pkg::LINK_W;
	localparam int NW = fla_pkg::LEN_W;
	localparam int AW = fla_pkg::ADDR_W;
	localparam int PW = NW + 1;

	// block table
	fla_pkg::entry_t mem [fla_pkg::GRAN_N];
	fla_pkg::entry_t rdata_q, wr_data;
	logic            rd_en, wr_en;
	logic [GW-1:0]   rd_addr, wr_addr;

	// control registers
	logic [1:0]    fit_q;
	logic [LW-1:0] head_q;
	logic          out_valid_q;

	// request and walk registers
	logic [NW-1:0] size_q, need_q, best_q, worst_q, clen_q, offset_q, zl_q;
	logic [NW-1:0] plen_q, tlen_q, nxlen_q, cur_b_q;
	logic [AW-1:0] addr_q, zb_q, res_addr_q, out_addr_q;
	logic [LW-1:0] cur_q, prev_q, chosen_q, cprev_q, clink_q, repl_q;
	logic [LW-1:0] p_q, plink_q, t_q, tlink_q;
	logic          p_null_q;
	logic [1:0]    res_st_q, out_st_q;
	logic [GW-1:0] z_q;

	// allocate evaluation
	logic [NW-1:0] slack, total, offset, nxt_b;
	logic          ge, gt, take, brk, split, first_pol;
	logic [LW-1:0] r_gran;
	logic [PW-1:0] p_end, t_end;
	logic          p_adj;

	always_comb begin
		ge = rdata_q.len >= need_q;
		gt = rdata_q.len > need_q;
		slack = rdata_q.len - need_q;
		first_pol = (fit_q != fla_pkg::POL_BEST) && (fit_q != fla_pkg::POL_WORST);
		unique case (fit_q)
			fla_pkg::POL_WORST: take = gt && (slack >= worst_q);
			fla_pkg::POL_BEST: take = ge && (slack < best_q);
			default: take = ge;
		endcase
		brk = first_pol && ge;
		// round need up to the granule, absorb a small leftover
		total = (need_q + NW'(fla_pkg::ALIGN_BYTES - 1))
			& ~NW'(fla_pkg::ALIGN_BYTES - 1);
		if (total >= clen_q) offset = clen_q;
		else if (clen_q - total <= NW'(fla_pkg::FREE_HEADER_BYTES + 1)) offset = clen_q;
		else offset = total;
		split = offset < clen_q;
		r_gran = chosen_q + LW'(offset >> $clog2(fla_pkg::ALIGN_BYTES));
		nxt_b = cur_b_q + rdata_q.len;
		p_end = PW'({p_q[GW-1:0], 3'b000}) + PW'(plen_q);
		p_adj = p_end == PW'(zb_q);
		t_end = PW'({t_q[GW-1:0], 3'b000}) + PW'(tlen_q);
	end

	// status toward the controller
	always_comb begin
		stat.size_zero    = size_q == '0;
		stat.head_null    = head_q[GW];
		stat.a_more       = !brk && !rdata_q.link[GW];
		stat.a_found      = !chosen_q[GW];
		stat.a_cprev_null = cprev_q[GW];
		stat.f_bad        = (addr_q < AW'(fla_pkg::ALLOC_HEADER_BYTES)) || (addr_q[2:0] != 3'b000);
		stat.f_head_full  = !head_q[GW] && (rdata_q.len == fla_pkg::FULL_LEN);
		stat.f_chain_hit  = !rdata_q.is_free && (cur_b_q == NW'(zb_q));
		stat.f_chain_end  = (rdata_q.len == '0) || (nxt_b >= NW'(fla_pkg::ARENA_BYTES));
		stat.f_list_start = !head_q[GW] && (head_q[GW-1:0] < z_q);
		stat.f_list_more  = !rdata_q.link[GW] && (rdata_q.link[GW-1:0] < z_q);
		stat.f_ins_two    = !p_null_q && !p_adj;
		stat.f_merge      = !tlink_q[GW] && (PW'({tlink_q[GW-1:0], 3'b000}) == t_end);
		stat.out_free     = !out_valid_q || out_ready;
	end

	// memory port selection
	always_comb begin
		rd_en = 1'b0;
		rd_addr = head_q[GW-1:0];
		wr_en = 1'b0;
		wr_addr = chosen_q[GW-1:0];
		wr_data = '{is_free: 1'b0, link: fla_pkg::LINK_NIL, len: offset_q};
		unique case (cmd)
			fla_pkg::C_INIT: begin
				wr_en = 1'b1;
				wr_addr = fla_pkg::FIRST_GRAN[GW-1:0];
				wr_data = '{is_free: 1'b1, link: fla_pkg::LINK_NIL, len: fla_pkg::FULL_LEN};
			end
			fla_pkg::C_A_START, fla_pkg::C_F_START, fla_pkg::C_F_LSTART: begin
				rd_en = !head_q[GW];
				rd_addr = head_q[GW-1:0];
			end
			fla_pkg::C_A_EVAL: begin
				rd_en = stat.a_more;
				rd_addr = rdata_q.link[GW-1:0];
			end
			fla_pkg::C_A_FINISH: begin
				wr_en = stat.a_found && split;
				wr_addr = r_gran[GW-1:0];
				wr_data = '{is_free: 1'b1, link: clink_q, len: clen_q - offset};
			end
			fla_pkg::C_A_PREV_RD: begin
				rd_en = 1'b1;
				rd_addr = cprev_q[GW-1:0];
			end
			fla_pkg::C_A_PREV_WR: begin
				wr_en = 1'b1;
				wr_addr = cprev_q[GW-1:0];
				wr_data = '{is_free: rdata_q.is_free, link: repl_q, len: rdata_q.len};
			end
			fla_pkg::C_A_CHOSEN_WR: begin
				wr_en = 1'b1;
				wr_addr = chosen_q[GW-1:0];
				wr_data = '{is_free: 1'b0, link: fla_pkg::LINK_NIL, len: offset_q};
			end
			fla_pkg::C_F_HEAD: begin
				rd_en = 1'b1;
				rd_addr = fla_pkg::FIRST_GRAN[GW-1:0];
			end
			fla_pkg::C_F_CHAIN: begin
				rd_en = !stat.f_chain_hit && !stat.f_chain_end;
				rd_addr = nxt_b[NW-2:3];
			end
			fla_pkg::C_F_LIST: begin
				rd_en = stat.f_list_more;
				rd_addr = rdata_q.link[GW-1:0];
			end
			fla_pkg::C_F_INS: begin
				wr_en = 1'b1;
				priority if (p_null_q) begin
					wr_addr = z_q;
					wr_data = '{is_free: 1'b1, link: head_q, len: zl_q};
				end else if (p_adj) begin
					wr_addr = p_q[GW-1:0];
					wr_data = '{is_free: 1'b1, link: plink_q, len: plen_q + zl_q};
				end else begin
					wr_addr = z_q;
					wr_data = '{is_free: 1'b1, link: plink_q, len: zl_q};
				end
			end
			fla_pkg::C_F_INS2: begin
				wr_en = 1'b1;
				wr_addr = p_q[GW-1:0];
				wr_data = '{is_free: 1'b1, link: LW'(z_q), len: plen_q};
			end
			fla_pkg::C_F_NEXT: begin
				rd_en = stat.f_merge;
				rd_addr = tlink_q[GW-1:0];
			end
			fla_pkg::C_F_MERGE: begin
				wr_en = 1'b1;
				wr_addr = t_q[GW-1:0];
				wr_data = '{is_free: 1'b1, link: rdata_q.link, len: tlen_q + rdata_q.len};
			end
			fla_pkg::C_F_MERGE2: begin
				wr_en = 1'b1;
				wr_addr = tlink_q[GW-1:0];
				wr_data = '{is_free: 1'b0, link: fla_pkg::LINK_NIL, len: nxlen_q};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// block table storage
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// replacement link for the chosen block's list slot
	function automatic logic [LW-1:0] repl_nx();
		return split ? r_gran : clink_q;
	endfunction

	// control registers: policy, list head, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q <= fla_pkg::POL_BEST;
			head_q <= fla_pkg::FIRST_GRAN;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) fit_q <= fit_policy;
			if (cmd == fla_pkg::C_INIT) head_q <= fla_pkg::FIRST_GRAN;
			if (cmd == fla_pkg::C_A_FINISH && stat.a_found && cprev_q[GW])
				head_q <= repl_nx();
			if (cmd == fla_pkg::C_F_INS && p_null_q) head_q <= LW'(z_q);
			if (cmd == fla_pkg::C_RESP && stat.out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			fla_pkg::C_IDLE: begin
				if (in_valid) begin
					size_q <= NW'(alloc_size);
					addr_q <= free_addr;
				end
			end
			fla_pkg::C_A_START: begin
				need_q <= size_q + NW'(fla_pkg::ALLOC_HEADER_BYTES);
				cur_q <= head_q;
				prev_q <= fla_pkg::LINK_NIL;
				chosen_q <= fla_pkg::LINK_NIL;
				cprev_q <= fla_pkg::LINK_NIL;
				best_q <= NW'(fla_pkg::ARENA_BYTES);
				worst_q <= '0;
				res_addr_q <= '0;
				res_st_q <= fla_pkg::ST_ALLOC_FAIL;
			end
			fla_pkg::C_A_EVAL: begin
				if (take) begin
					chosen_q <= cur_q;
					cprev_q <= prev_q;
					clen_q <= rdata_q.len;
					clink_q <= rdata_q.link;
					best_q <= slack;
					worst_q <= slack;
				end
				prev_q <= cur_q;
				cur_q <= rdata_q.link;
			end
			fla_pkg::C_A_FINISH: begin
				offset_q <= offset;
				repl_q <= repl_nx();
			end
			fla_pkg::C_A_CHOSEN_WR: begin
				res_addr_q <= AW'({chosen_q[GW-1:0], 3'b000} + (GW + 3)'(fla_pkg::ALLOC_HEADER_BYTES));
				res_st_q <= fla_pkg::ST_OK;
			end
			fla_pkg::C_F_START: begin
				zb_q <= addr_q - AW'(fla_pkg::ALLOC_HEADER_BYTES);
				z_q <= GW'((addr_q - AW'(fla_pkg::ALLOC_HEADER_BYTES)) >> 3);
				res_addr_q <= '0;
				res_st_q <= fla_pkg::ST_FREE_REJ;
			end
			fla_pkg::C_F_HEAD: cur_b_q <= NW'(fla_pkg::ARENA_HEADER_BYTES);
			fla_pkg::C_F_CHAIN: begin
				zl_q <= rdata_q.len;
				cur_b_q <= nxt_b;
			end
			fla_pkg::C_F_LSTART: p_null_q <= 1'b1;
			fla_pkg::C_F_LIST: begin
				p_null_q <= 1'b0;
				p_q <= cur_q;
				plen_q <= rdata_q.len;
				plink_q <= rdata_q.link;
			end
			fla_pkg::C_F_INS: begin
				res_st_q <= fla_pkg::ST_OK;
				priority if (p_null_q) begin
					t_q <= LW'(z_q);
					tlen_q <= zl_q;
					tlink_q <= head_q;
				end else if (p_adj) begin
					t_q <= p_q;
					tlen_q <= plen_q + zl_q;
					tlink_q <= plink_q;
				end else begin
					t_q <= LW'(z_q);
					tlen_q <= zl_q;
					tlink_q <= plink_q;
				end
			end
			fla_pkg::C_F_MERGE: nxlen_q <= rdata_q.len;
			fla_pkg::C_RESP: begin
				if (stat.out_free) begin
					out_addr_q <= res_addr_q;
					out_st_q <= res_st_q;
				end
			end
			default: begin
			end
		endcase
		// the free list walk tracks its granule in cur_q as well
		if (cmd == fla_pkg::C_F_LSTART) cur_q <= head_q;
		if (cmd == fla_pkg::C_F_LIST) cur_q <= rdata_q.link;
	end

	assign out_valid = out_valid_q;
	assign result_addr = out_addr_q;
	assign status = out_st_q;

endmodule

// ----- sv/free_list_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// free_list_heap_allocator: heap allocator over a 4 KiB arena
// address-ordered free list, first/best/worst fit, coalescing free
// ---------------------------------------------------------------------------
// allocate: walks the free list, one free block visited per cycle, and
//   rewrites the predecessor's link when the chosen block is not the list head
// free: walks the chain of B blocks up to the address, then the P free blocks
//   below it, with extra table writes for a split insert and a right merge
// one request at a time; a result waits in the output register while the
//   next request is accepted
// reset: asynchronous; the init state after reset seeds the whole-arena free block
// ---------------------------------------------------------------------------
module free_list_heap_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [fla_pkg::SIZE_W-1:0]   alloc_size,
	input  logic [fla_pkg::ADDR_W-1:0]   free_addr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fla_pkg::ADDR_W-1:0]   result_addr,
	output logic [1:0]                   status,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   fit_policy
);

	fla_pkg::cmd_t  cmd;
	fla_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	// sequencer
	fla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// table and registers
	fla_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_valid    (in_valid),
		.alloc_size  (alloc_size),
		.free_addr   (free_addr),
		.cfg_valid   (cfg_valid),
		.fit_policy  (fit_policy),
		.out_ready   (out_ready),
		.stat        (stat),
		.out_valid   (out_valid),
		.result_addr (result_addr),
		.status      (status)
	);

	// checks
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fla_pkg::ST_OK |-> result_addr == '0)
		else $error("nonzero address on a failed request");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

endmodule
